// File: hw/rtl/lra_pkg.sv
// Shared constants and types for the list rank assigner.
`default_nettype none
package lra_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int RANK_W       = 7;

	// Control from the sequencer to the compare/count unit.
	typedef struct packed {
		logic clr;
		logic acc;
	} lra_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/list_rank_assigner_top.sv
// List rank assigner: stores a sequence and emits each element's rank.
//
// Input: an item (value, is_last) is taken on a clock edge with start high
// and busy low. Items without is_last are stored at that edge and busy stays
// low, so they may arrive back to back. Up to CAPACITY values are kept;
// further ones are discarded and flag dropped on every result of the batch.
// The item with is_last closes the batch: busy rises and one result per
// stored value follows, in arrival order, each shown for one cycle with
// strobe high. rank = 1 + number of stored values strictly smaller.
// For each result with n stored values the sequencer reads the key, latches
// it, makes n compares through the single shared comparator fed by the one
// read port of the store, then emits. busy falls in the cycle the final
// result is shown, and a new item may be taken then. Results cannot be held
// off by the receiver.
// Reset clears the sequencer, the count and the overflow flag; the store
// itself is not cleared and needs no clearing pass.
`default_nettype none
module list_rank_assigner_top
	import lra_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               is_last,
	output logic                    strobe,
	output logic      [RANK_W-1:0]  rank,
	output logic                    last_rank,
	output logic                    dropped
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_I,
		S_KEY,
		S_CMP,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic               ovf_q;
	logic [VALUE_W-1:0] key_q;
	logic               strobe_q;
	logic [RANK_W-1:0]  rank_q;
	logic               last_rank_q;
	logic               dropped_q;

	logic               accept;
	logic               room;
	logic               we;
	logic [AW-1:0]      raddr;
	logic [VALUE_W-1:0] rdata_q;
	logic [RANK_W-1:0]  smaller_q;
	lra_ctl_t           ctl;
	logic               i_final;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign room    = (cnt_q < CW'(CAPACITY));
	assign we      = accept && room;
	assign i_final = (CW'(i_q + CW'(1)) == n_q);

	always_comb begin
		raddr = i_q[AW-1:0];
		if (state_q == S_CMP || state_q == S_KEY) begin
			raddr = j_q[AW-1:0];
		end
	end

	assign ctl.clr = (state_q == S_KEY);
	assign ctl.acc = (state_q == S_CMP);

	lra_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (cnt_q[AW-1:0]),
		.wdata  (value),
		.raddr  (raddr),
		.rdata_q(rdata_q)
	);

	lra_rank_unit u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.data     (rdata_q),
		.key      (key_q),
		.smaller_q(smaller_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ovf_q       <= 1'b0;
			strobe_q    <= 1'b0;
			rank_q      <= '0;
			last_rank_q <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
							n_q   <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
							n_q   <= cnt_q;
						end
						if (is_last) begin
							i_q     <= '0;
							state_q <= S_RD_I;
						end
					end
				end
				S_RD_I: begin
					// read of element i issued; zero j for the compare sweep
					j_q     <= '0;
					state_q <= S_KEY;
				end
				S_KEY: begin
					// key arrives; element 0 read issued this cycle
					j_q     <= CW'(1);
					state_q <= S_CMP;
				end
				S_CMP: begin
					// rdata_q holds the element issued last cycle
					if (j_q == n_q) begin
						state_q <= S_DONE;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_DONE: begin
					strobe_q    <= 1'b1;
					rank_q      <= smaller_q + RANK_W'(1);
					last_rank_q <= i_final;
					dropped_q   <= ovf_q;
					if (i_final) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_RD_I;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_KEY) begin
			key_q <= rdata_q;
		end
	end

	assign strobe    = strobe_q;
	assign rank      = rank_q;
	assign last_rank = last_rank_q;
	assign dropped   = dropped_q;

endmodule
`default_nettype wire

// File: hw/rtl/lra_store.sv
// Value store: one write port, one registered read port.
`default_nettype none
module lra_store
	import lra_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [VALUE_W-1:0] wdata,
	input  wire logic [AW-1:0]      raddr,
	output logic      [VALUE_W-1:0] rdata_q
);

	logic [VALUE_W-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/lra_rank_unit.sv
// Shared signed comparator with a count of values smaller than the key.
`default_nettype none
module lra_rank_unit
	import lra_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lra_ctl_t           ctl,
	input  wire logic [VALUE_W-1:0] data,
	input  wire logic [VALUE_W-1:0] key,
	output logic      [RANK_W-1:0]  smaller_q
);

	logic lt;

	assign lt = $signed(data) < $signed(key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smaller_q <= '0;
		end else if (ctl.clr) begin
			smaller_q <= '0;
		end else if (ctl.acc && lt) begin
			smaller_q <= smaller_q + RANK_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: tb/list_rank_assigner_top_tb.sv
// Self-checking testbench for the list rank assigner: directed table, then random batches.
`default_nettype none
module list_rank_assigner_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lra_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 20;
	localparam int ITEM_TARGET = 170;
	localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              last_rank;
		logic              dropped;
	} rank_res_t;

	// typed rows close a one-element batch whose single result is written in
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
		logic               typed;
		rank_res_t          res;
	} dir_row_t;

	localparam rank_res_t SOLO = '{rank: 7'd1, last_rank: 1'b1, dropped: 1'b0};
	localparam rank_res_t NONE = '{rank: 7'd0, last_rank: 1'b0, dropped: 1'b0};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               is_last;
	logic               strobe;
	logic [RANK_W-1:0]  rank;
	logic               last_rank;
	logic               dropped;

	dir_row_t dir_tab [20] = '{
		'{VAL_MAX, 1'b1, 1'b1, SOLO},
		'{VAL_MIN, 1'b1, 1'b1, SOLO},
		'{32'h0, 1'b1, 1'b1, SOLO},
		// all equal: every rank is 1
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NONE},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NONE},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, NONE},
		// sign boundary and extremes mixed
		'{32'h0, 1'b0, 1'b0, NONE},
		'{VAL_MIN, 1'b0, 1'b0, NONE},
		'{VAL_MAX, 1'b0, 1'b0, NONE},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, NONE},
		'{32'h1, 1'b0, 1'b0, NONE},
		'{32'h4000_0000, 1'b0, 1'b0, NONE},
		'{32'hBFFF_FFFF, 1'b1, 1'b0, NONE},
		// pairs of ties around a middle value
		'{32'h7, 1'b0, 1'b0, NONE},
		'{32'h3, 1'b0, 1'b0, NONE},
		'{32'h7, 1'b0, 1'b0, NONE},
		'{32'h3, 1'b0, 1'b0, NONE},
		'{32'h5, 1'b1, 1'b0, NONE},
		'{VAL_MAX, 1'b0, 1'b0, NONE},
		'{VAL_MIN, 1'b1, 1'b0, NONE}
	};

	logic signed [VALUE_W-1:0] held_vals [$];
	bit                        held_overflow;
	rank_res_t                 batch_q [$];
	rank_res_t                 rank_q [$];
	int                        n_sent;
	int                        n_errs;
	int                        n_cycles;

	list_rank_assigner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.is_last   (is_last),
		.strobe    (strobe),
		.rank      (rank),
		.last_rank (last_rank),
		.dropped   (dropped)
	);

	always #6 clk = ~clk;

	// Store or discard one value; on the closing item rank the whole batch.
	function automatic void take_value(logic [VALUE_W-1:0] v, logic last);
		int r;
		rank_res_t res;
		if (held_vals.size() < CAPACITY_DEF)
			held_vals.push_back(v);
		else
			held_overflow = 1'b1;
		if (!last)
			return;
		for (int i = 0; i < held_vals.size(); i++) begin
			r = 1;
			for (int j = 0; j < held_vals.size(); j++)
				if (held_vals[j] < held_vals[i])
					r++;
			res.rank = r[RANK_W-1:0];
			res.last_rank = (i == held_vals.size() - 1);
			res.dropped = held_overflow;
			batch_q.push_back(res);
		end
		held_vals.delete();
		held_overflow = 1'b0;
	endfunction

	function automatic int idle_pct();
		if (n_sent < ITEM_TARGET / 3)
			return 21;
		else if (n_sent < 2 * ITEM_TARGET / 3)
			return 52;
		return 0;
	endfunction

	// Mix of ties around zero, extremes and full-range values.
	function automatic logic [VALUE_W-1:0] rand_value();
		int sel;
		sel = $urandom_range(7);
		case (sel)
			0, 1: begin
				return $urandom_range(6) - 3;
			end
			2: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic last,
			input logic typed, input rank_res_t typed_res);
		// idle decided per cycle so the idle share matches the percentage
		while ($urandom_range(99) < idle_pct()) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		value = v;
		is_last = last;
		do @(posedge clk); while (busy);
		take_value(v, last);
		if (typed) begin
			batch_q.delete();
			rank_q.push_back(typed_res);
		end else begin
			while (batch_q.size() != 0)
				rank_q.push_back(batch_q.pop_front());
		end
		n_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		rank_res_t want;
		if (arst_n && strobe) begin
			if (rank_q.size() == 0) begin
				$display("%0t: result with nothing expected: rank %0d last_rank %0b dropped %0b",
					$time, rank, last_rank, dropped);
				n_errs++;
			end else begin
				want = rank_q.pop_front();
				if (rank !== want.rank) begin
					$display("%0t: rank expected %0d actual %0d", $time, want.rank, rank);
					n_errs++;
				end
				if (last_rank !== want.last_rank) begin
					$display("%0t: last_rank expected %0b actual %0b",
						$time, want.last_rank, last_rank);
					n_errs++;
				end
				if (dropped !== want.dropped) begin
					$display("%0t: dropped expected %0b actual %0b",
						$time, want.dropped, dropped);
					n_errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int batch_no;
		int len;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		is_last = 1'b0;
		n_sent = 0;
		n_errs = 0;
		n_cycles = 0;
		held_overflow = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[k])
			send_item(dir_tab[k].value, dir_tab[k].is_last, dir_tab[k].typed, dir_tab[k].res);

		// mostly short batches; one exactly full, one that overflows on its tail
		batch_no = 0;
		while (n_sent < ITEM_TARGET) begin
			if (batch_no == 2)
				len = CAPACITY_DEF;
			else if (batch_no == 5)
				len = CAPACITY_DEF + 2;
			else
				len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send_item(rand_value(), i == len - 1, 1'b0, NONE);
			batch_no++;
		end
		start = 1'b0;

		while (rank_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_errs == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
